// ===== hw/rtl/activity_interval_statistics_assert.svh =====
// Assertion macros shared by the activity interval statistics RTL.
`ifndef ACTIVITY_INTERVAL_STATISTICS_ASSERT_SVH
`define ACTIVITY_INTERVAL_STATISTICS_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define AIS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define AIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ais_pkg.sv =====
// Package with types, widths and state encodings for the activity interval statistics block.
`default_nettype none

package ais_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 65536;
  localparam int unsigned DUR_W             = 32;
  localparam int unsigned TOTAL_W           = 48;
  localparam int unsigned SHARE_W           = 14;
  localparam int unsigned CUT_W             = 16;
  localparam int unsigned COUNT_W           = 17;
  localparam int unsigned DIV_W             = 48;
  localparam int unsigned SHARE_SCALE       = 10000;

  typedef struct packed {
    logic [DUR_W-1:0] duration_ms;
    logic             last;
  } ais_in_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_ms;
    logic [DUR_W-1:0]   official_ms;
    logic [DUR_W-1:0]   active_ms;
    logic [DUR_W-1:0]   max_active_ms;
    logic [DUR_W-1:0]   max_inactive_ms;
    logic [DUR_W-1:0]   avg_active_ms;
    logic [DUR_W-1:0]   avg_inactive_ms;
    logic [SHARE_W-1:0] active_share;
    logic               clipped;
    logic [CUT_W-1:0]   cut_position;
    logic [COUNT_W-1:0] interval_count;
  } ais_out_t;

  // Session sums handed from the accumulator to the result stage
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [DUR_W-1:0]   active;
    logic [DUR_W-1:0]   longest_active;
    logic [DUR_W-1:0]   longest_inactive;
    logic               cut_seen;
    logic [CUT_W-1:0]   cut_index;
  } ais_sums_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_SUM,
    A_PART,
    A_UPD
  } acc_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACCUM,
    S_OFFICIAL,
    S_PRODUCT,
    S_DA_GO,
    S_DA_RUN,
    S_DI_GO,
    S_DI_RUN,
    S_DS_GO,
    S_DS_RUN,
    S_FINISH
  } ais_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ais_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle; a zero divisor yields zero.
`default_nettype none

module ais_divider
  import ais_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DUR_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(DIV_W);

  logic              busy_r;
  logic              done_r;
  logic              zero_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DUR_W-1:0]  rem_r;
  logic [DUR_W-1:0]  dsr_r;
  logic [DIV_W-1:0]  quo_r;

  logic [DUR_W:0]    trial;
  logic [DUR_W:0]    diff;
  logic              fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    diff  = trial - {1'b0, dsr_r};
    fits  = trial >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
        zero_r <= (divisor == '0);
      end else if (busy_r) begin
        rem_r <= fits ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], fits};
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = zero_r ? '0 : quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ais_accum.sv =====
// Bit-serial session accumulator: running total, window clipping, sums, maxima and counts.
`default_nettype none
`include "activity_interval_statistics_assert.svh"

module ais_accum
  import ais_pkg::*;
#(
  parameter  int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF,
  localparam int unsigned CNT_W         = $clog2(MAX_INTERVALS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             clear,
  input  logic [DUR_W-1:0] duration,
  input  logic [DUR_W-1:0] window,
  output logic             done,
  output ais_sums_t        sums,
  output logic [CNT_W-1:0] act_cnt,
  output logic [CNT_W-1:0] inact_cnt,
  output logic [CNT_W-1:0] pos
);

  localparam int unsigned STEP_W = $clog2(TOTAL_W);

  acc_state_t state_r, state_nxt;

  // Session state
  logic [TOTAL_W-1:0] rt_r;
  logic [DUR_W-1:0]   as_r;
  logic [DUR_W-1:0]   la_r;
  logic [DUR_W-1:0]   li_r;
  logic [CNT_W-1:0]   act_r;
  logic [CNT_W-1:0]   inact_r;
  logic [CNT_W-1:0]   pos_r;
  logic               cut_r;
  logic [CUT_W-1:0]   cix_r;

  // Per-item serial working registers
  logic [DUR_W-1:0]   d_r;
  logic [DUR_W-1:0]   wsh_r;
  logic [DUR_W-1:0]   diff_r;
  logic [DUR_W-1:0]   part_r;
  logic [STEP_W-1:0]  cnt_r;
  logic               c_r;
  logic               b_r;
  logic               ge_r;
  logic               le_r;
  logic               pc_r;
  logic               gt_r;
  logic               ne_r;
  logic               take_r;

  logic room;
  logic odd;
  logic lo;
  logic p_bit, d_bit, w_bit;
  logic s_bit, s_cy;
  logic ge_step, le_step;
  logic df_bit, df_bw;
  logic q_bit, a_bit, l_bit;
  logic as_bit, as_cy;
  logic gt_step, ne_step;
  logic sum_end, part_end;

  assign room     = pos_r < CNT_W'(MAX_INTERVALS);
  assign odd      = pos_r[0];
  assign lo       = cnt_r < STEP_W'(DUR_W);
  assign sum_end  = cnt_r == STEP_W'(TOTAL_W - 1);
  assign part_end = cnt_r == STEP_W'(DUR_W - 1);

  // Pass one: total plus duration, compare with the window, window minus total
  always_comb begin
    p_bit   = rt_r[0];
    d_bit   = lo & d_r[0];
    w_bit   = wsh_r[0];
    s_bit   = p_bit ^ d_bit ^ c_r;
    s_cy    = (p_bit & d_bit) | (p_bit & c_r) | (d_bit & c_r);
    ge_step = (s_bit != w_bit) ? s_bit : ge_r;
    le_step = (p_bit != w_bit) ? w_bit : le_r;
    df_bit  = w_bit ^ p_bit ^ b_r;
    df_bw   = (~w_bit & p_bit) | (~(w_bit ^ p_bit) & b_r);
  end

  // Pass two: counted part, added to the active sum and compared with the longest
  always_comb begin
    q_bit   = ge_r ? (le_r & diff_r[0]) : d_r[0];
    a_bit   = as_r[0];
    as_bit  = a_bit ^ q_bit ^ pc_r;
    as_cy   = (a_bit & q_bit) | (a_bit & pc_r) | (q_bit & pc_r);
    l_bit   = odd ? la_r[0] : li_r[0];
    gt_step = (q_bit != l_bit) ? q_bit : gt_r;
    ne_step = ne_r | (q_bit ^ d_r[0]);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE: begin
        if (start && !clear) begin
          state_nxt = room ? A_SUM : A_UPD;
        end
      end
      A_SUM: begin
        if (sum_end) begin
          state_nxt = cut_r ? A_UPD : A_PART;
        end
      end
      A_PART: begin
        if (part_end) begin
          state_nxt = A_UPD;
        end
      end
      A_UPD:   state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = 1'b0;
    case (state_r)
      A_UPD:   done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      rt_r    <= '0;
      as_r    <= '0;
      la_r    <= '0;
      li_r    <= '0;
      act_r   <= '0;
      inact_r <= '0;
      pos_r   <= '0;
      cut_r   <= 1'b0;
      cix_r   <= '0;
      cnt_r   <= '0;
      take_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        A_IDLE: begin
          if (clear) begin
            // Drop the session
            rt_r    <= '0;
            as_r    <= '0;
            la_r    <= '0;
            li_r    <= '0;
            act_r   <= '0;
            inact_r <= '0;
            pos_r   <= '0;
            cut_r   <= 1'b0;
            cix_r   <= '0;
          end else if (start) begin
            d_r    <= duration;
            wsh_r  <= window;
            cnt_r  <= '0;
            c_r    <= 1'b0;
            b_r    <= 1'b0;
            ge_r   <= 1'b1;
            le_r   <= 1'b1;
            take_r <= room;
          end
        end
        A_SUM: begin
          rt_r  <= {s_bit, rt_r[TOTAL_W-1:1]};
          c_r   <= s_cy;
          ge_r  <= ge_step;
          le_r  <= le_step;
          wsh_r <= {1'b0, wsh_r[DUR_W-1:1]};
          cnt_r <= cnt_r + STEP_W'(1);
          if (lo) begin
            d_r    <= {d_r[0], d_r[DUR_W-1:1]};
            diff_r <= {df_bit, diff_r[DUR_W-1:1]};
            b_r    <= df_bw;
          end
          if (sum_end) begin
            // Saturate on carry out; a carry also means past the window
            if (s_cy) begin
              rt_r <= '1;
            end
            ge_r  <= s_cy | ge_step;
            cnt_r <= '0;
            pc_r  <= 1'b0;
            gt_r  <= 1'b0;
            ne_r  <= 1'b0;
          end
        end
        A_PART: begin
          if (odd) begin
            as_r <= {as_bit, as_r[DUR_W-1:1]};
            la_r <= {la_r[0], la_r[DUR_W-1:1]};
          end else begin
            li_r <= {li_r[0], li_r[DUR_W-1:1]};
          end
          pc_r   <= as_cy;
          gt_r   <= gt_step;
          ne_r   <= ne_step;
          part_r <= {q_bit, part_r[DUR_W-1:1]};
          d_r    <= {d_r[0], d_r[DUR_W-1:1]};
          diff_r <= {1'b0, diff_r[DUR_W-1:1]};
          cnt_r  <= cnt_r + STEP_W'(1);
        end
        A_UPD: begin
          cnt_r <= '0;
          if (take_r) begin
            pos_r <= pos_r + CNT_W'(1);
            if (!cut_r) begin
              if (odd) begin
                act_r <= act_r + CNT_W'(1);
                if (gt_r) begin
                  la_r <= part_r;
                end
              end else begin
                inact_r <= inact_r + CNT_W'(1);
                if (gt_r) begin
                  li_r <= part_r;
                end
              end
              if (ne_r) begin
                cut_r <= 1'b1;
                cix_r <= CUT_W'(pos_r);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign sums.total            = rt_r;
  assign sums.active           = as_r;
  assign sums.longest_active   = la_r;
  assign sums.longest_inactive = li_r;
  assign sums.cut_seen         = cut_r;
  assign sums.cut_index        = cix_r;
  assign act_cnt               = act_r;
  assign inact_cnt             = inact_r;
  assign pos                   = pos_r;

  `AIS_ASSERT_IMPL(a_clear_when_idle, clear, state_r == A_IDLE, "session clear while busy")
  `AIS_ASSERT_IMPL(a_pos_bound, 1'b1, pos_r <= CNT_W'(MAX_INTERVALS), "position past capacity")
  `AIS_ASSERT_NEXT(a_cut_sticky, cut_r && !clear, cut_r, "cut flag lost within session")

endmodule

`default_nettype wire

// ===== hw/rtl/activity_interval_statistics.sv =====
// Top level of the activity interval statistics block: handshakes, result stage and sequencing.
//
// Takes a session of interval durations in ms (position 0 is the start marker, even
// positions inactive, odd ones active) and on the item flagged last returns one result
// with totals, maxima, averages and the active share, then starts a new session.
// One item is in work at a time; in_stall is high while it is. An ordinary item goes
// through a bit-serial pass that adds it to the running total and compares against
// the window, a bit-serial pass that forms the counted part and updates the active
// sum and maxima, then an update state and the return to idle. Once the window is
// cut the second pass is left out; an item past the session capacity is dropped
// without either pass. The last item then goes through the official-time and product
// preparation states, three 48-step radix-2 divisions (averages and share) on one
// shared divider, each with its start and run states, and a finish state, held while
// an earlier result still waits on out_stall. The result sits in an output register,
// so the next item is taken while it waits on out_stall.
`default_nettype none
`include "activity_interval_statistics_assert.svh"

module activity_interval_statistics
  import ais_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ais_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ais_out_t         out_data,
  input  logic             cfg_we,
  input  logic [DUR_W-1:0] cfg_wdata
);

  localparam int unsigned CNT_W  = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned PROD_W = DUR_W + SHARE_W;

  ais_state_t state_r, state_nxt;

  logic [DUR_W-1:0]  window_r;
  logic              last_r;
  logic [DUR_W-1:0]  official_r;
  logic [DUR_W-1:0]  inact_time_r;
  logic [PROD_W-1:0] prod_r;
  logic [DUR_W-1:0]  avg_a_r;
  logic [DUR_W-1:0]  avg_i_r;
  logic [SHARE_W-1:0] share_r;
  logic              out_valid_r;
  ais_out_t          out_data_r;

  logic              acc_start;
  logic              acc_done;
  logic              sess_clear;
  ais_sums_t         sums;
  logic [CNT_W-1:0]  act_cnt;
  logic [CNT_W-1:0]  inact_cnt;
  logic [CNT_W-1:0]  pos;

  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  div_dividend;
  logic [DUR_W-1:0]  div_divisor;
  logic [DIV_W-1:0]  div_quotient;
  logic              out_free;
  logic              div_wait;

  assign out_free = !out_valid_r || !out_stall;
  assign div_wait = (state_r == S_DA_RUN) || (state_r == S_DI_RUN) || (state_r == S_DS_RUN);

  ais_accum #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (acc_start),
    .clear     (sess_clear),
    .duration  (in_data.duration_ms),
    .window    (window_r),
    .done      (acc_done),
    .sums      (sums),
    .act_cnt   (act_cnt),
    .inact_cnt (inact_cnt),
    .pos       (pos)
  );

  ais_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_ACCUM;
      S_ACCUM:    if (acc_done) state_nxt = last_r ? S_OFFICIAL : S_IDLE;
      S_OFFICIAL: state_nxt = S_PRODUCT;
      S_PRODUCT:  state_nxt = S_DA_GO;
      S_DA_GO:    state_nxt = S_DA_RUN;
      S_DA_RUN:   if (div_done) state_nxt = S_DI_GO;
      S_DI_GO:    state_nxt = S_DI_RUN;
      S_DI_RUN:   if (div_done) state_nxt = S_DS_GO;
      S_DS_GO:    state_nxt = S_DS_RUN;
      S_DS_RUN:   if (div_done) state_nxt = S_FINISH;
      S_FINISH:   if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall   = 1'b1;
    acc_start  = 1'b0;
    div_start  = 1'b0;
    sess_clear = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        acc_start = in_valid;
      end
      S_DA_GO, S_DI_GO, S_DS_GO: div_start = 1'b1;
      S_FINISH:                  sess_clear = out_free;
      default:                   ;
    endcase
  end

  // Divider operands for each of the three divisions
  always_comb begin
    div_dividend = '0;
    div_divisor  = '0;
    case (state_r)
      S_DA_GO: begin
        div_dividend = DIV_W'(sums.active);
        div_divisor  = DUR_W'(act_cnt);
      end
      S_DI_GO: begin
        div_dividend = DIV_W'(inact_time_r);
        div_divisor  = (inact_cnt > CNT_W'(1)) ? DUR_W'(inact_cnt - CNT_W'(1)) : '0;
      end
      S_DS_GO: begin
        div_dividend = DIV_W'(prod_r);
        div_divisor  = official_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      window_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
    end
  end

  // Result datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_r <= in_data.last;
        end
      end
      S_OFFICIAL: begin
        official_r <= (sums.total < TOTAL_W'(window_r)) ? sums.total[DUR_W-1:0] : window_r;
      end
      S_PRODUCT: begin
        prod_r       <= PROD_W'(sums.active) * PROD_W'(SHARE_SCALE);
        inact_time_r <= (official_r >= sums.active) ? official_r - sums.active : '0;
      end
      S_DA_RUN: if (div_done) avg_a_r <= div_quotient[DUR_W-1:0];
      S_DI_RUN: if (div_done) avg_i_r <= div_quotient[DUR_W-1:0];
      S_DS_RUN: if (div_done) share_r <= div_quotient[SHARE_W-1:0];
      default:  ;
    endcase
  end

  // Output register: load on finish, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sess_clear) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sess_clear) begin
      out_data_r.total_ms        <= sums.total;
      out_data_r.official_ms     <= official_r;
      out_data_r.active_ms       <= sums.active;
      out_data_r.max_active_ms   <= sums.longest_active;
      out_data_r.max_inactive_ms <= sums.longest_inactive;
      out_data_r.avg_active_ms   <= avg_a_r;
      out_data_r.avg_inactive_ms <= avg_i_r;
      out_data_r.active_share    <= share_r;
      out_data_r.clipped         <= sums.cut_seen;
      out_data_r.cut_position    <= sums.cut_seen ? sums.cut_index : '0;
      out_data_r.interval_count  <= COUNT_W'(pos);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `AIS_ASSERT_IMPL(a_out_from_finish, $rose(out_valid_r), $past(sess_clear), "stray result")
  `AIS_ASSERT_IMPL(a_acc_done_state, acc_done, state_r == S_ACCUM, "accumulator done early")
  `AIS_ASSERT_IMPL(a_div_done_state, div_done, div_wait, "divider done while not waiting")

endmodule

`default_nettype wire
